>>> hdl/b64gd_pkg.sv
// shared types and constants for the base64 group decoder
// no dependencies; imported by every module of the block

package b64gd_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int SEXTET_W   = 6;
   localparam int COUNT_W    = 16;
   localparam int NUM_LANES  = 4;

   // bytes produced by one decoded group
   localparam logic [COUNT_W-1:0] GROUP_BYTES = 16'd3;

   // largest output capacity honored on a start word
   localparam logic [31:0] CAPACITY_MAX = 32'd65535;

   // one character lane: 6-bit value and in-alphabet flag
   typedef struct packed {
      logic                ok;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   // one result word
   typedef struct packed {
      logic [CHAR_W-1:0]  byte0;
      logic [CHAR_W-1:0]  byte1;
      logic [CHAR_W-1:0]  byte2;
      logic               accepted;
      logic [COUNT_W-1:0] total_bytes;
   } result_type;

endpackage

>>> hdl/b64gd_lane.sv
// one character lane: maps a character through the base64 alphabet
// depends on b64gd_pkg

module b64gd_lane (
   input  logic [b64gd_pkg::CHAR_W-1:0] ch,
   output b64gd_pkg::sextet_type        sextet
);
   import b64gd_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;

   // offsets that move each range onto its sextet values
   localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd71;  // 'a' maps to 26
   localparam logic [CHAR_W-1:0] DIGIT_OFS = 8'd4;   // '0' maps to 52

   localparam logic [SEXTET_W-1:0] VAL_PLUS  = 6'd62;
   localparam logic [SEXTET_W-1:0] VAL_SLASH = 6'd63;
   localparam logic [SEXTET_W-1:0] VAL_PAD   = 6'd0;

   logic [CHAR_W-1:0] diff;

   // range compare and offset per alphabet block
   always_comb begin
      diff         = '0;
      sextet.ok    = 1'b1;
      sextet.value = '0;
      if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         diff         = ch - CHAR_UPPER_A;
         sextet.value = diff[SEXTET_W-1:0];
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         diff         = ch - LOWER_OFS;
         sextet.value = diff[SEXTET_W-1:0];
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         diff         = ch + DIGIT_OFS;
         sextet.value = diff[SEXTET_W-1:0];
      end else if (ch == CHAR_PLUS) begin
         sextet.value = VAL_PLUS;
      end else if (ch == CHAR_SLASH) begin
         sextet.value = VAL_SLASH;
      end else if (ch == CHAR_PAD) begin
         sextet.value = VAL_PAD;
      end else begin
         sextet.ok = 1'b0;
      end
   end

endmodule

>>> hdl/b64gd_merge.sv
// merge stage: joins the four lanes, keeps the per-string state and
// forms the result word; depends on b64gd_pkg

module b64gd_merge (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  push,
   input  logic                                                  start_req,
   input  logic [b64gd_pkg::COUNT_W-1:0]                         capacity,
   input  b64gd_pkg::sextet_type [b64gd_pkg::NUM_LANES-1:0]      lanes,
   output b64gd_pkg::result_type                                 result
);
   import b64gd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               halted_ff, halted_in;
   logic [COUNT_W-1:0] cap_ff, cap_in;

   logic [COUNT_W-1:0] start_cap;
   logic [COUNT_W-1:0] cur_count;
   logic               cur_halted;
   logic [COUNT_W:0]   next_end;
   logic               room;
   logic               all_ok;
   logic               attempt;
   logic               acc;
   logic [COUNT_W:0]   count_sum;

   // capacity latched on a start word, limited to the maximum
   always_comb begin
      if ({16'd0, capacity} > CAPACITY_MAX) begin
         start_cap = CAPACITY_MAX[COUNT_W-1:0];
      end else begin
         start_cap = capacity;
      end
   end

   // state as seen by this word, after a possible start
   always_comb begin
      cap_in     = start_req ? start_cap : cap_ff;
      cur_count  = start_req ? '0 : count_ff;
      cur_halted = start_req ? 1'b0 : halted_ff;
   end

   // capacity check and alphabet check over all lanes
   always_comb begin
      next_end  = {1'b0, cur_count} + {1'b0, GROUP_BYTES};
      room      = next_end < {1'b0, cap_in};
      all_ok    = lanes[0].ok & lanes[1].ok & lanes[2].ok & lanes[3].ok;
      attempt   = !cur_halted && room;
      acc       = attempt && all_ok;
      count_sum = {1'b0, cur_count} + {1'b0, GROUP_BYTES};
      count_in  = acc ? count_sum[COUNT_W-1:0] : cur_count;
      halted_in = cur_halted || (attempt && !all_ok);
   end

   // result word: bytes from the sextets, zero when rejected
   always_comb begin
      result.accepted    = acc;
      result.total_bytes = count_in;
      if (acc) begin
         result.byte0 = {lanes[0].value, lanes[1].value[5:4]};
         result.byte1 = {lanes[1].value[3:0], lanes[2].value[5:2]};
         result.byte2 = {lanes[2].value[1:0], lanes[3].value};
      end else begin
         result.byte0 = '0;
         result.byte1 = '0;
         result.byte2 = '0;
      end
   end

   // per-string state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         halted_ff <= 1'b1;
         cap_ff    <= '0;
      end else if (push) begin
         count_ff  <= count_in;
         halted_ff <= halted_in;
         cap_ff    <= cap_in;
      end
   end

endmodule

>>> hdl/b64gd_outbuf.sv
// two-entry result buffer: output register plus skid register
// depends on b64gd_pkg

module b64gd_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64gd_pkg::result_type push_word,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output b64gd_pkg::result_type out_word
);
   import b64gd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_word_ff, out_word_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_word_ff, skid_word_in;
   logic       take;

   assign take      = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   // refill from skid first, else from the incoming word
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_word_in  = push_word;
         end else begin
            skid_valid_in = 1'b1;
            skid_word_in  = push_word;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

>>> hdl/base64_group_decoder_core.sv
// Each result word is registered in the output register, or in the skid one
// when that is busy. Throughput: one four-character group per cycle unless
// stalled; the byte count updates in merge, and the two-entry buffer keeps
// input flowing while one result waits. req_stall rises only when both fill.
// Reset (synchronous): count and capacity clear, the block waits for a start
// word (every group rejected until then), and the output buffer empties.

module base64_group_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_start_req,
   input  logic [b64gd_pkg::COUNT_W-1:0]     req_capacity,
   input  logic [b64gd_pkg::CHAR_W-1:0]      req_ch0,
   input  logic [b64gd_pkg::CHAR_W-1:0]      req_ch1,
   input  logic [b64gd_pkg::CHAR_W-1:0]      req_ch2,
   input  logic [b64gd_pkg::CHAR_W-1:0]      req_ch3,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte0,
   output logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte1,
   output logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte2,
   output logic                              rsp_accepted,
   output logic [b64gd_pkg::COUNT_W-1:0]     rsp_total_bytes
);
   import b64gd_pkg::*;

   logic [NUM_LANES-1:0][CHAR_W-1:0] chars;
   sextet_type [NUM_LANES-1:0]       lanes;
   result_type                       result;
   result_type                       out_word;
   logic                             push;
   logic                             full;

   assign chars     = {req_ch3, req_ch2, req_ch1, req_ch0};
   assign req_stall = full;
   assign push      = req_valid && !full;

   // one alphabet lane per character
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      b64gd_lane u_lane (
         .ch     (chars[i]),
         .sextet (lanes[i])
      );
   end

   // merge lanes and update string state
   b64gd_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .start_req (req_start_req),
      .capacity  (req_capacity),
      .lanes     (lanes),
      .result    (result)
   );

   // output register and skid
   b64gd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_byte0       = out_word.byte0;
   assign rsp_byte1       = out_word.byte1;
   assign rsp_byte2       = out_word.byte2;
   assign rsp_accepted    = out_word.accepted;
   assign rsp_total_bytes = out_word.total_bytes;

endmodule

>>> hdl/b64gd_checker.sv
// port-level checks for the base64 group decoder
// depends on b64gd_pkg; bound to base64_group_decoder_core

module b64gd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte0,
   input logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte1,
   input logic [b64gd_pkg::CHAR_W-1:0]      rsp_byte2,
   input logic                              rsp_accepted,
   input logic [b64gd_pkg::COUNT_W-1:0]     rsp_total_bytes
);
   import b64gd_pkg::*;

   // output buffer empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // a rejected group carries zero bytes
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |->
         rsp_byte0 == '0 && rsp_byte1 == '0 && rsp_byte2 == '0)
      else $error("rejected group with nonzero bytes");

   // an accepted group has at least one group counted
   a_accept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_total_bytes >= GROUP_BYTES)
      else $error("accepted group with byte total below one group");

   // a stalled result word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte0) &&
         $stable(rsp_byte1) && $stable(rsp_byte2) &&
         $stable(rsp_accepted) && $stable(rsp_total_bytes))
      else $error("stalled result word changed");

endmodule

bind base64_group_decoder_core b64gd_checker u_b64gd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_byte0       (rsp_byte0),
   .rsp_byte1       (rsp_byte1),
   .rsp_byte2       (rsp_byte2),
   .rsp_accepted    (rsp_accepted),
   .rsp_total_bytes (rsp_total_bytes)
);
